// ----- hw/rtl/bjct_pkg.sv -----
// ============================================================================
// bjct_pkg
// Shared types and constants of the blocked jump chain table.
// ============================================================================
package bjct_pkg;

  // Default number of table positions
  localparam int unsigned TABLE_SIZE_DEF = 1024;

  // Block shift register
  localparam int unsigned BLK_SHIFT_W   = 4;
  localparam logic [3:0]  BLK_SHIFT_RST = 4'd5;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W      = 2;
  localparam logic [1:0]  CFG_POSITIONS  = 2'd0;
  localparam logic [1:0]  CFG_BLK_SHIFT  = 2'd1;

  typedef enum logic [0:0] {
    CMD_SET   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  // Shortcut rebuild classification of one entry
  typedef enum logic [1:0] {
    RB_EXIT   = 2'd0,   // jump leaves the table
    RB_DIRECT = 2'd1,   // jump leaves the block
    RB_COPY   = 2'd2    // jump stays in block, inherit target's shortcut
  } rb_kind_e;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_CLEAR   = 5'b00010,
    ST_REBUILD = 5'b00100,
    ST_WALK    = 5'b01000,
    ST_RESP    = 5'b10000
  } state_e;

endpackage

// ----- hw/rtl/bjct_ram.sv -----
// ============================================================================
// bjct_ram
// Generic single-write, single-read RAM, registered read (read-first).
// ============================================================================
module bjct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bjct_rebuild.sv -----
// ============================================================================
// bjct_rebuild
// Shortcut rebuild engine: walks positions hi down to lo, one per cycle.
// Three stages: length read, shortcut read at destination, shortcut write.
// ============================================================================
module bjct_rebuild
  import bjct_pkg::*;
#(
  parameter int unsigned TableSize = TABLE_SIZE_DEF,
  localparam int unsigned IdxW = $clog2(TableSize),
  localparam int unsigned CntW = IdxW + 1,
  localparam int unsigned SW   = 1 + IdxW + CntW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [IdxW-1:0]        hi_i,
  input  logic [IdxW-1:0]        lo_i,
  input  logic [CntW-1:0]        n_i,
  input  logic [BLK_SHIFT_W-1:0] bs_i,
  output logic                   done_o,
  output logic [IdxW-1:0]        len_raddr_o,
  input  logic [CntW-1:0]        len_rdata_i,
  output logic [IdxW-1:0]        sc_raddr_o,
  input  logic [SW-1:0]          sc_rdata_i,
  output logic                   sc_we_o,
  output logic [IdxW-1:0]        sc_waddr_o,
  output logic [SW-1:0]          sc_wdata_o
);

  logic            run_q, run_d;
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [IdxW-1:0] lo_q, lo_d;
  // stage A: length data back
  logic            va_q, va_d;
  logic [IdxW-1:0] ia_q, ia_d;
  // stage B: shortcut data back
  logic            vb_q, vb_d;
  logic [IdxW-1:0] ib_q, ib_d;
  logic [IdxW-1:0] db_q, db_d;
  rb_kind_e        kb_q, kb_d;
  // last write, for the back-to-back hazard
  logic            fwv_q, fwv_d;
  logic [IdxW-1:0] fwa_q, fwa_d;
  logic [SW-1:0]   fwd_q, fwd_d;

  logic [CntW:0] dest_a;
  logic [CntW:0] ia_ext;
  logic [SW-1:0] src_b;
  logic [SW-1:0] wdata;

  assign ia_ext = {2'b00, ia_q};
  assign dest_a = ia_ext + {1'b0, len_rdata_i};

  always_comb begin
    run_d = run_q;
    ptr_d = ptr_q;
    lo_d  = lo_q;
    va_d  = 1'b0;
    ia_d  = ptr_q;
    vb_d  = va_q;
    ib_d  = ia_q;
    db_d  = dest_a[IdxW-1:0];
    kb_d  = RB_COPY;

    if (len_rdata_i == '0 || dest_a >= {1'b0, n_i}) begin
      kb_d = RB_EXIT;
    end else if ((dest_a >> bs_i) != (ia_ext >> bs_i)) begin
      kb_d = RB_DIRECT;
    end

    if (run_q) begin
      va_d = 1'b1;
      if (ptr_q == lo_q) begin
        run_d = 1'b0;
      end else begin
        ptr_d = ptr_q - IdxW'(1);
      end
    end

    if (start_i) begin
      run_d = 1'b1;
      ptr_d = hi_i;
      lo_d  = lo_i;
      va_d  = 1'b0;
      vb_d  = 1'b0;
    end
  end

  // stage B: build the entry
  assign src_b = (fwv_q && fwa_q == db_q) ? fwd_q : sc_rdata_i;

  always_comb begin
    case (kb_q)
      RB_EXIT:   wdata = {1'b1, IdxW'(0), CntW'(1)};
      RB_DIRECT: wdata = {1'b0, db_q, CntW'(1)};
      default:   wdata = {src_b[SW-1:CntW], src_b[CntW-1:0] + CntW'(1)};
    endcase
  end

  assign fwv_d = vb_q && !start_i;
  assign fwa_d = ib_q;
  assign fwd_d = wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
      fwv_q <= 1'b0;
    end else begin
      run_q <= run_d;
      va_q  <= va_d;
      vb_q  <= vb_d;
      fwv_q <= fwv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    lo_q  <= lo_d;
    ia_q  <= ia_d;
    ib_q  <= ib_d;
    db_q  <= db_d;
    kb_q  <= kb_d;
    fwa_q <= fwa_d;
    fwd_q <= fwd_d;
  end

  assign len_raddr_o = ptr_q;
  assign sc_raddr_o  = dest_a[IdxW-1:0];
  assign sc_we_o     = vb_q;
  assign sc_waddr_o  = ib_q;
  assign sc_wdata_o  = wdata;
  assign done_o      = vb_q && !va_q && !run_q;

endmodule

// ----- hw/rtl/bjct_walk.sv -----
// ============================================================================
// bjct_walk
// Query walker: follows shortcuts, then single jumps, one hop per cycle.
// ============================================================================
module bjct_walk
  import bjct_pkg::*;
#(
  parameter int unsigned TableSize = TABLE_SIZE_DEF,
  localparam int unsigned IdxW = $clog2(TableSize),
  localparam int unsigned CntW = IdxW + 1,
  localparam int unsigned SW   = 1 + IdxW + CntW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [IdxW-1:0] idx_i,
  input  logic [CntW-1:0] n_i,
  output logic [IdxW-1:0] raddr_o,
  input  logic [CntW-1:0] len_rdata_i,
  input  logic [SW-1:0]   sc_rdata_i,
  output logic            done_o,
  output logic [IdxW-1:0] pos_o,
  output logic [CntW-1:0] cnt_o
);

  logic            run_q, run_d;
  logic            ph2_q, ph2_d;
  logic [IdxW-1:0] j_q, j_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic            sc_exit;
  logic [IdxW-1:0] sc_tgt;
  logic [CntW-1:0] sc_cnt;
  logic [CntW:0]   hop;

  assign sc_exit = sc_rdata_i[SW-1];
  assign sc_tgt  = sc_rdata_i[SW-2 -: IdxW];
  assign sc_cnt  = sc_rdata_i[CntW-1:0];
  assign hop     = {2'b00, j_q} + {1'b0, len_rdata_i};

  always_comb begin
    run_d  = run_q;
    ph2_d  = ph2_q;
    j_d    = j_q;
    cnt_d  = cnt_q;
    done_o = 1'b0;
    if (start_i) begin
      run_d = 1'b1;
      ph2_d = 1'b0;
      j_d   = idx_i;
      cnt_d = CntW'(1);
    end else if (run_q) begin
      if (!ph2_q) begin
        if (!sc_exit && {1'b0, sc_tgt} < n_i) begin
          j_d   = sc_tgt;
          cnt_d = cnt_q + sc_cnt;
        end else begin
          ph2_d = 1'b1;   // re-read j for the single-jump phase
        end
      end else if (sc_cnt != CntW'(1) && len_rdata_i != '0 && hop < {1'b0, n_i}) begin
        j_d   = hop[IdxW-1:0];
        cnt_d = cnt_q + CntW'(1);
      end else begin
        run_d  = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ph2_q <= ph2_d;
    j_q   <= j_d;
    cnt_q <= cnt_d;
  end

  assign raddr_o = j_d;
  assign pos_o   = j_q;
  assign cnt_o   = cnt_q;

endmodule

// ----- hw/rtl/blocked_jump_chain_table.sv -----
// ============================================================================
// blocked_jump_chain_table
// Forward jump table with per-block shortcuts (square-root decomposition).
// ============================================================================
// Usage:
//   Slave stream takes one command item: tuser = command (set / query),
//   tdata = index, jump length. Master stream returns one result item per
//   command: tdata = last position, jump count; tuser = error flag.
//   Config writes (cfg_we_i) set positions in use (0) or block shift (1).
// Timing:
//   Set    : shortcuts rebuilt from index down to block start, one entry a cycle.
//   Query  : shortcut hops, then single jumps in the last block (about
//            2*sqrt(N) hops when the block size is near sqrt(N)).
//   Error or zero-length set: no walk or rebuild, straight to the result.
//   Config : from idle, full shortcut rebuild of all positions, input held off.
//   The rate is set by the shortcut RAM read loop (one hop per cycle).
// Reset:
//   A clearing pass writes every entry (length zero, exit shortcut, count
//   one); no item is taken until it ends.
// Backpressure:
//   The result sits in an output register; the next item is accepted
//   while it waits. A new result waits in the FSM until that slot frees.
// ============================================================================
module blocked_jump_chain_table
  import bjct_pkg::*;
#(
  parameter int unsigned TableSize = TABLE_SIZE_DEF,
  localparam int unsigned IdxW  = $clog2(TableSize),
  localparam int unsigned CntW  = IdxW + 1,
  localparam int unsigned SW    = 1 + IdxW + CntW,
  localparam int unsigned DataW = ((IdxW + CntW + 7) / 8) * 8,
  localparam int unsigned CfgW  = (CntW > BLK_SHIFT_W) ? CntW : BLK_SHIFT_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DataW-1:0]     s_axis_tdata,   // index, jump_length, zero pad
  input  logic [0:0]           s_axis_tuser,   // command
  // result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DataW-1:0]     m_axis_tdata,   // last_position, jump_count, zero pad
  output logic [0:0]           m_axis_tuser,   // error
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_data_i
);

  state_e state_q, state_d;

  logic [CntW-1:0]        pos_use_q;
  logic [BLK_SHIFT_W-1:0] bs_q;
  logic [IdxW-1:0]        clr_q, clr_d;
  logic                   rb_full_q, rb_full_d;

  // pending result
  logic [IdxW-1:0] res_pos_q, res_pos_d;
  logic [CntW-1:0] res_cnt_q, res_cnt_d;
  logic            res_err_q, res_err_d;

  // output register
  logic            out_vld_q, out_vld_d;
  logic [IdxW-1:0] out_pos_q;
  logic [CntW-1:0] out_cnt_q;
  logic            out_err_q;
  logic            out_load;

  logic [CntW-1:0] n_use;
  logic            acc;
  cmd_e            in_cmd;
  logic [IdxW-1:0] in_idx;
  logic [CntW-1:0] in_len;
  logic            in_err;
  logic            cfg_hit;

  // engines
  logic            rb_start, rb_done;
  logic [IdxW-1:0] rb_hi, rb_lo;
  logic [IdxW-1:0] rb_len_raddr, rb_sc_raddr, rb_sc_waddr;
  logic            rb_sc_we;
  logic [SW-1:0]   rb_sc_wdata;
  logic            wk_start, wk_done;
  logic [IdxW-1:0] wk_raddr, wk_pos;
  logic [CntW-1:0] wk_cnt;

  // memories
  logic            len_we;
  logic [IdxW-1:0] len_waddr, len_raddr;
  logic [CntW-1:0] len_wdata, len_rdata;
  logic            sc_we;
  logic [IdxW-1:0] sc_waddr, sc_raddr;
  logic [SW-1:0]   sc_wdata, sc_rdata;

  assign n_use   = (pos_use_q > CntW'(TableSize)) ? CntW'(TableSize) : pos_use_q;
  assign in_cmd  = cmd_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[IdxW-1:0];
  assign in_len  = s_axis_tdata[IdxW +: CntW];
  assign in_err  = {1'b0, in_idx} >= n_use;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc     = s_axis_tvalid && s_axis_tready;
  assign cfg_hit = cfg_we_i && (cfg_idx_i == CFG_POSITIONS || cfg_idx_i == CFG_BLK_SHIFT);

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    rb_full_d = rb_full_q;
    res_pos_d = res_pos_q;
    res_cnt_d = res_cnt_q;
    res_err_d = res_err_q;
    rb_start  = 1'b0;
    rb_hi     = in_idx;
    rb_lo     = (in_idx >> bs_q) << bs_q;
    wk_start  = 1'b0;
    len_we    = 1'b0;
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          res_pos_d = '0;
          res_cnt_d = '0;
          res_err_d = in_err;
          if (in_err) begin
            state_d = ST_RESP;
          end else if (in_cmd == CMD_QUERY) begin
            wk_start = 1'b1;
            state_d  = ST_WALK;
          end else if (in_len == '0) begin
            state_d = ST_RESP;
          end else begin
            len_we    = 1'b1;
            rb_start  = 1'b1;
            rb_full_d = 1'b0;
            state_d   = ST_REBUILD;
          end
        end else if (cfg_hit) begin
          rb_start  = 1'b1;
          rb_full_d = 1'b1;
          rb_hi     = IdxW'(TableSize - 1);
          rb_lo     = '0;
          state_d   = ST_REBUILD;
        end
      end
      ST_CLEAR: begin
        // config writes land in the registers; cleared table is consistent
        if (clr_q == IdxW'(TableSize - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + IdxW'(1);
        end
      end
      ST_REBUILD: begin
        if (cfg_hit && rb_full_q) begin
          rb_start = 1'b1;    // register moved again: start over
          rb_hi    = IdxW'(TableSize - 1);
          rb_lo    = '0;
        end else if (rb_done) begin
          state_d = rb_full_q ? ST_IDLE : ST_RESP;
        end
      end
      ST_WALK: begin
        if (wk_done) begin
          res_pos_d = wk_pos;
          res_cnt_d = wk_cnt;
          res_err_d = 1'b0;
          state_d   = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q && !m_axis_tready;
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      rb_full_q <= 1'b0;
      out_vld_q <= 1'b0;
      pos_use_q <= CntW'(TableSize);
      bs_q      <= BLK_SHIFT_RST;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      rb_full_q <= rb_full_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i && cfg_idx_i == CFG_POSITIONS) begin
        pos_use_q <= cfg_data_i[CntW-1:0];
      end
      if (cfg_we_i && cfg_idx_i == CFG_BLK_SHIFT) begin
        bs_q <= cfg_data_i[BLK_SHIFT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_pos_q <= res_pos_d;
    res_cnt_q <= res_cnt_d;
    res_err_q <= res_err_d;
    if (out_load) begin
      out_pos_q <= res_pos_q;
      out_cnt_q <= res_cnt_q;
      out_err_q <= res_err_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = DataW'({out_cnt_q, out_pos_q});
  assign m_axis_tuser  = out_err_q;

  // ---------------------------------------------------------------------------
  // Memory ports: clear pass, set, rebuild engine and walker share them
  // ---------------------------------------------------------------------------
  always_comb begin
    if (state_q == ST_CLEAR) begin
      len_waddr = clr_q;
      len_wdata = '0;
      sc_we     = 1'b1;
      sc_waddr  = clr_q;
      sc_wdata  = {1'b1, IdxW'(0), CntW'(1)};
    end else begin
      len_waddr = in_idx;
      len_wdata = in_len;
      sc_we     = rb_sc_we;
      sc_waddr  = rb_sc_waddr;
      sc_wdata  = rb_sc_wdata;
    end
    if (state_q == ST_REBUILD) begin
      len_raddr = rb_len_raddr;
      sc_raddr  = rb_sc_raddr;
    end else begin
      len_raddr = wk_raddr;
      sc_raddr  = wk_raddr;
    end
  end

  bjct_ram #(
    .Width (CntW),
    .Depth (TableSize)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we || state_q == ST_CLEAR),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  bjct_ram #(
    .Width (SW),
    .Depth (TableSize)
  ) u_sc_ram (
    .clk_i   (clk_i),
    .we_i    (sc_we),
    .waddr_i (sc_waddr),
    .wdata_i (sc_wdata),
    .raddr_i (sc_raddr),
    .rdata_o (sc_rdata)
  );

  bjct_rebuild #(
    .TableSize (TableSize)
  ) u_rebuild (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (rb_start),
    .hi_i        (rb_hi),
    .lo_i        (rb_lo),
    .n_i         (n_use),
    .bs_i        (bs_q),
    .done_o      (rb_done),
    .len_raddr_o (rb_len_raddr),
    .len_rdata_i (len_rdata),
    .sc_raddr_o  (rb_sc_raddr),
    .sc_rdata_i  (sc_rdata),
    .sc_we_o     (rb_sc_we),
    .sc_waddr_o  (rb_sc_waddr),
    .sc_wdata_o  (rb_sc_wdata)
  );

  bjct_walk #(
    .TableSize (TableSize)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (wk_start),
    .idx_i       (in_idx),
    .n_i         (n_use),
    .raddr_o     (wk_raddr),
    .len_rdata_i (len_rdata),
    .sc_rdata_i  (sc_rdata),
    .done_o      (wk_done),
    .pos_o       (wk_pos),
    .cnt_o       (wk_cnt)
  );

endmodule
